>>> src/fss_pkg.sv
// Shared types and signature tables for the file signature scanner.
package fss_pkg;

  localparam int NUM_SIGS    = 8;
  localparam int SIG_MAX_LEN = 16;
  localparam int AVAIL_W     = 5;
  localparam int TYPE_W      = 3;
  localparam int LIMIT_W     = 27;
  localparam int OFF_W       = 48;
  localparam int FLUSH_MAX   = 16;
  localparam int FLUSH_CNT_W = 5;

  localparam logic [7:0] MAX_HITS_RST = 8'd200;

  typedef enum logic [0:0] {
    REG_BASE_OFFSET = 1'b0,
    REG_MAX_HITS    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic               is_hit;
    logic [OFF_W-1:0]   hit_offset;
    logic [TYPE_W-1:0]  type_code;
    logic [LIMIT_W-1:0] size_limit;
    logic               last;
  } hit_rec_t;

  // jpeg, png, pdf, zip, elf, sqlite, gzip, macho; unused tail bytes are zero
  localparam logic [7:0] SIG_BYTES [NUM_SIGS][SIG_MAX_LEN] = '{
    '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7F, 8'h45, 8'h4C, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h51, 8'h4C, 8'h69, 8'h74, 8'h65, 8'h20, 8'h66,
      8'h6F, 8'h72, 8'h6D, 8'h61, 8'h74, 8'h20, 8'h33, 8'h00},
    '{8'h1F, 8'h8B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hCF, 8'hFA, 8'hED, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [AVAIL_W-1:0] SIG_LEN [NUM_SIGS] = '{
    5'd3, 5'd8, 5'd5, 5'd4, 5'd4, 5'd16, 5'd2, 5'd4
  };

  localparam logic [LIMIT_W-1:0] SIG_LIMIT [NUM_SIGS] = '{
    27'd10485760, 27'd10485760, 27'd52428800, 27'd104857600,
    27'd20971520, 27'd52428800, 27'd52428800, 27'd20971520
  };

endpackage

>>> src/fss_matcher.sv
// Compares the leading window bytes against all eight magic signatures.
module fss_matcher (
  input  logic [fss_pkg::SIG_MAX_LEN*8-1:0] win_bytes_i,
  input  logic [fss_pkg::AVAIL_W-1:0]       avail_i,
  output logic                              match_o,
  output logic [fss_pkg::TYPE_W-1:0]        type_code_o
);

  logic [fss_pkg::NUM_SIGS-1:0] sig_ok;

  always_comb begin
    for (int s = 0; s < fss_pkg::NUM_SIGS; s++) begin
      // a signature only counts when it lies wholly inside the valid bytes
      sig_ok[s] = (fss_pkg::SIG_LEN[s] <= avail_i);
      for (int b = 0; b < fss_pkg::SIG_MAX_LEN; b++) begin
        if ((fss_pkg::AVAIL_W'(b) < fss_pkg::SIG_LEN[s]) &&
            (win_bytes_i[b*8 +: 8] != fss_pkg::SIG_BYTES[s][b])) begin
          sig_ok[s] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    match_o     = |sig_ok;
    type_code_o = '0;
    for (int s = fss_pkg::NUM_SIGS - 1; s >= 0; s--) begin
      if (sig_ok[s]) begin
        type_code_o = fss_pkg::TYPE_W'(s);
      end
    end
  end

endmodule

>>> src/fss_out_buf.sv
// Two-entry skid buffer holding result records for the output channel.
module fss_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  fss_pkg::hit_rec_t push_rec_i,
  output logic              can_push_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fss_pkg::hit_rec_t out_rec_o
);

  fss_pkg::hit_rec_t main_r;
  fss_pkg::hit_rec_t skid_r;
  logic              main_v_r;
  logic              skid_v_r;
  logic              pop;

  assign pop         = main_v_r && out_ready_i;
  assign can_push_o  = !skid_v_r;
  assign out_valid_o = main_v_r;
  assign out_rec_o   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      // refill the output stage from the skid stage
      if (pop) begin
        main_r   <= skid_r;
        skid_v_r <= 1'b0;
      end
    end else if (push_i) begin
      if (!main_v_r || pop) begin
        main_r   <= push_rec_i;
        main_v_r <= 1'b1;
      end else begin
        skid_r   <= push_rec_i;
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

endmodule

>>> src/file_signature_scanner.sv
// Top level: byte stream magic-number scanner with look-ahead window.
//
// Usage: raw device bytes enter on the in_ channel, one per request, with
// in_tlast on the final byte of a scanned region. Each hit leaves on the
// out_ channel as a record (offset, type code, carve limit), in offset
// order; out_tuser flags a real hit, out_tlast marks the end of a scan.
// base_offset and max_hits are written on the cfg_ port between scans.
// Throughput: one byte per cycle while streaming, unless the output buffer
// is full. A position is tested as soon as WINDOW_BYTES bytes from it are
// buffered; its record is pushed to the output buffer in the cycle that
// accepts the byte completing the window. End of stream: after the in_tlast
// byte a separate flush matcher walks the window one slot per cycle while
// the buffer has room, and in_tready stays low until the closing record
// is pushed: the last pending hit, or an empty record, with out_tlast set.
// A stalled receiver fills the two-entry output buffer, which then drops
// in_tready and holds the flush walk; no record is lost.
// Reset (rst_n low, synchronous) empties the window and the buffer, clears
// position and hit count and sets base_offset to 0 and max_hits to 200.
module file_signature_scanner #(
  parameter int WINDOW_BYTES = 16,
  parameter int OFFSET_BITS  = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [47:0] hit_offset, [50:48] type_code,
                                  // [77:51] size_limit, [79:78] zero
  output logic        out_tuser,  // [0] is_hit
  output logic        out_tlast,  // last
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);

  localparam int FillW = $clog2(WINDOW_BYTES + 1);
  localparam int SlotW = $clog2(WINDOW_BYTES);

  logic [47:0]             base_offset_r;
  logic [7:0]              max_hits_r;
  logic [7:0]              window_r   [WINDOW_BYTES];
  logic [7:0]              window_nxt [WINDOW_BYTES];
  logic [7:0]              cand       [WINDOW_BYTES];
  logic [FillW-1:0]        fill_r, fill_nxt;
  logic [OFFSET_BITS-1:0]  pos_r, pos_nxt, pos_inc, off_sum;
  logic [7:0]              hits_r, hits_nxt;
  logic                    flushing_r, flushing_nxt;
  logic                    pend_v_r, pend_v_nxt;
  fss_pkg::hit_rec_t       pend_r, pend_nxt;
  logic [fss_pkg::FLUSH_CNT_W-1:0] femit_r, femit_nxt;

  logic [fss_pkg::SIG_MAX_LEN*8-1:0] norm_bytes, flush_bytes;
  logic [fss_pkg::AVAIL_W-1:0]       flush_avail;
  logic                              norm_match, flush_match;
  logic [fss_pkg::TYPE_W-1:0]        norm_type, flush_type, sel_type;
  fss_pkg::hit_rec_t                 hit_rec, push_rec, out_rec;
  logic                              push, can_push, in_acc, norm_full;
  logic                              cap_ok, flush_hit_ok;

  assign in_tready = !flushing_r && can_push;
  assign in_acc    = in_tvalid && in_tready;
  assign norm_full = (fill_r == FillW'(WINDOW_BYTES - 1));
  assign cap_ok    = (hits_r < max_hits_r);
  assign pos_inc   = (pos_r != '1) ? pos_r + OFFSET_BITS'(1) : pos_r;
  assign off_sum   = pos_r + OFFSET_BITS'(base_offset_r);

  // window with the incoming byte placed at the fill point
  always_comb begin
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      cand[i] = window_r[i];
    end
    cand[fill_r[SlotW-1:0]] = in_tdata;
  end

  always_comb begin
    for (int b = 0; b < fss_pkg::SIG_MAX_LEN; b++) begin
      norm_bytes[b*8 +: 8]  = cand[b];
      flush_bytes[b*8 +: 8] = window_r[b];
    end
    if (fill_r >= FillW'(fss_pkg::SIG_MAX_LEN)) begin
      flush_avail = fss_pkg::AVAIL_W'(fss_pkg::SIG_MAX_LEN);
    end else begin
      flush_avail = fss_pkg::AVAIL_W'(fill_r);
    end
  end

  fss_matcher u_norm_match (
    .win_bytes_i (norm_bytes),
    .avail_i     (fss_pkg::AVAIL_W'(fss_pkg::SIG_MAX_LEN)),
    .match_o     (norm_match),
    .type_code_o (norm_type)
  );

  fss_matcher u_flush_match (
    .win_bytes_i (flush_bytes),
    .avail_i     (flush_avail),
    .match_o     (flush_match),
    .type_code_o (flush_type)
  );

  assign sel_type     = flushing_r ? flush_type : norm_type;
  assign flush_hit_ok = flush_match && cap_ok &&
                        (femit_r < fss_pkg::FLUSH_CNT_W'(fss_pkg::FLUSH_MAX));

  always_comb begin
    hit_rec            = '0;
    hit_rec.is_hit     = 1'b1;
    hit_rec.hit_offset = fss_pkg::OFF_W'(off_sum);
    hit_rec.type_code  = sel_type;
    hit_rec.size_limit = fss_pkg::SIG_LIMIT[sel_type];
  end

  always_comb begin
    window_nxt   = window_r;
    fill_nxt     = fill_r;
    pos_nxt      = pos_r;
    hits_nxt     = hits_r;
    flushing_nxt = flushing_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    femit_nxt    = femit_r;
    push         = 1'b0;
    push_rec     = hit_rec;
    if (flushing_r) begin
      if (can_push) begin
        if (fill_r != '0) begin
          // test the oldest slot, keep its hit pending until the next one
          if (flush_hit_ok) begin
            push       = pend_v_r;
            push_rec   = pend_r;
            pend_nxt   = hit_rec;
            pend_v_nxt = 1'b1;
            hits_nxt   = hits_r + 8'd1;
            femit_nxt  = femit_r + fss_pkg::FLUSH_CNT_W'(1);
          end
          for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
            window_nxt[i] = window_r[i + 1];
          end
          fill_nxt = fill_r - FillW'(1);
          pos_nxt  = pos_inc;
        end else begin
          push = 1'b1;
          if (pend_v_r) begin
            push_rec = pend_r;
          end else begin
            push_rec = '0;
          end
          push_rec.last = 1'b1;
          flushing_nxt  = 1'b0;
          pend_v_nxt    = 1'b0;
          fill_nxt      = '0;
          pos_nxt       = '0;
          hits_nxt      = '0;
          femit_nxt     = '0;
        end
      end
    end else if (in_acc) begin
      if (in_tlast) begin
        window_nxt   = cand;
        fill_nxt     = fill_r + FillW'(1);
        flushing_nxt = 1'b1;
      end else if (norm_full) begin
        push = norm_match && cap_ok;
        if (push) begin
          hits_nxt = hits_r + 8'd1;
        end
        for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
          window_nxt[i] = cand[i + 1];
        end
        pos_nxt = pos_inc;
      end else begin
        window_nxt = cand;
        fill_nxt   = fill_r + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    window_r <= window_nxt;
    pend_r   <= pend_nxt;
    if (!rst_n) begin
      fill_r     <= '0;
      pos_r      <= '0;
      hits_r     <= '0;
      flushing_r <= 1'b0;
      pend_v_r   <= 1'b0;
      femit_r    <= '0;
    end else begin
      fill_r     <= fill_nxt;
      pos_r      <= pos_nxt;
      hits_r     <= hits_nxt;
      flushing_r <= flushing_nxt;
      pend_v_r   <= pend_v_nxt;
      femit_r    <= femit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_offset_r <= '0;
      max_hits_r    <= fss_pkg::MAX_HITS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fss_pkg::REG_BASE_OFFSET: base_offset_r <= cfg_wdata;
        fss_pkg::REG_MAX_HITS:    max_hits_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  fss_out_buf u_out_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_rec_i  (push_rec),
    .can_push_o  (can_push),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_rec_o   (out_rec)
  );

  assign out_tdata = {2'b00, out_rec.size_limit, out_rec.type_code, out_rec.hit_offset};
  assign out_tuser = out_rec.is_hit;
  assign out_tlast = out_rec.last;

  a_eos_starts_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> flushing_r)
    else $error("end-of-stream byte did not start the flush");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !flushing_r |-> (fill_r < FillW'(WINDOW_BYTES)))
    else $error("window overfilled outside flush");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid && !flushing_r) |-> in_tready)
    else $error("input stalled with empty output buffer");

endmodule
